/* design/gpde_pkg.sv */
// ----------------------------------------------------------------------------
// gpde_pkg
// Shared constants, register codes and types of the grid-plane distance unit.
// ----------------------------------------------------------------------------
package gpde_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 63;

    localparam int POS_W     = 32;
    localparam int DERIV_W   = 31;
    localparam int SIZE_W    = 31;
    localparam int FRAC_W    = 16;
    localparam int COEF_W    = 21;
    localparam int COEF_FRAC = 19;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CELL_SIZE   = 3'd0,
        REG_Z_SCALE     = 3'd1,
        REG_LINE_OFFSET = 3'd2,
        REG_MODE_FLAGS  = 3'd3,
        REG_ROT_ROW_X   = 3'd4,
        REG_ROT_ROW_Y   = 3'd5,
        REG_ROT_ROW_Z   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic cheb;
        logic rot_en;
    } mode_t;

    localparam logic [SIZE_W-1:0]     CELL_SIZE_RST   = 31'd65536;
    localparam logic [SIZE_W-1:0]     Z_SCALE_RST     = 31'd65536;
    localparam logic [POS_W-1:0]      LINE_OFFSET_RST = 32'd328;
    localparam logic [CFG_DATA_W-1:0] ROT_ROW_X_RST   = 63'h0000_0000_0008_0000;
    localparam logic [CFG_DATA_W-1:0] ROT_ROW_Y_RST   = 63'h0000_0100_0000_0000;
    localparam logic [CFG_DATA_W-1:0] ROT_ROW_Z_RST   = 63'h2000_0000_0000_0000;

endpackage

/* design/gpde_udiv.sv */
// ----------------------------------------------------------------------------
// gpde_udiv
// Pipelined restoring divider: one quotient bit per stage, side data alongside.
// ----------------------------------------------------------------------------
module gpde_udiv #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 31,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quo,
    output logic [DEN_W-1:0]  rem,
    output logic [SIDE_W-1:0] side_out
);

    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [DEN_W-1:0]  rem_next [NUM_W];
    logic [NUM_W-1:0]  quo_reg  [NUM_W];
    logic [NUM_W-1:0]  quo_next [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [DEN_W-1:0]  den_next [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic [SIDE_W-1:0] side_next[NUM_W];
    logic [NUM_W-1:0]  vld_reg;
    logic [NUM_W-1:0]  vld_next;

    // Each stage shifts the top dividend bit into the partial remainder and
    // shifts the decision into the bottom of the quotient word.
    always_comb
    begin
        logic [DEN_W-1:0] rem_cur;
        logic [NUM_W-1:0] quo_cur;
        logic [DEN_W-1:0] den_cur;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;
        for (int k = 0; k < NUM_W; k++)
        begin
            if (k == 0)
            begin
                rem_cur      = '0;
                quo_cur      = num;
                den_cur      = den;
                side_next[k] = side_in;
                vld_next[k]  = in_valid;
            end
            else
            begin
                rem_cur      = rem_reg[k-1];
                quo_cur      = quo_reg[k-1];
                den_cur      = den_reg[k-1];
                side_next[k] = side_reg[k-1];
                vld_next[k]  = vld_reg[k-1];
            end
            trial       = {rem_cur, quo_cur[NUM_W-1]};
            diff        = trial - {1'b0, den_cur};
            take        = (trial >= {1'b0, den_cur});
            rem_next[k] = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next[k] = {quo_cur[NUM_W-2:0], take};
            den_next[k] = den_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign quo       = quo_reg[NUM_W-1];
    assign rem       = rem_reg[NUM_W-1];
    assign side_out  = side_reg[NUM_W-1];

endmodule

/* design/gpde_isqrt.sv */
// ----------------------------------------------------------------------------
// gpde_isqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module gpde_isqrt #(
    parameter int ROOT_W = 33,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*ROOT_W-1:0] rad,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   root,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int RAD_W = 2 * ROOT_W;

    logic [ROOT_W:0]   rem_reg  [ROOT_W];
    logic [ROOT_W:0]   rem_next [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [ROOT_W-1:0] root_next[ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_next [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];
    logic [SIDE_W-1:0] side_next[ROOT_W];
    logic [ROOT_W-1:0] vld_reg;
    logic [ROOT_W-1:0] vld_next;

    // The remainder never exceeds twice the partial root, so ROOT_W+1 bits
    // hold it; the trial subtrahend is 4*root+1.
    always_comb
    begin
        logic [ROOT_W:0]   rem_cur;
        logic [ROOT_W-1:0] root_cur;
        logic [RAD_W-1:0]  rad_cur;
        logic [ROOT_W+2:0] t;
        logic [ROOT_W+2:0] trial;
        logic [ROOT_W+2:0] diff;
        logic              take;
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (k == 0)
            begin
                rem_cur      = '0;
                root_cur     = '0;
                rad_cur      = rad;
                side_next[k] = side_in;
                vld_next[k]  = in_valid;
            end
            else
            begin
                rem_cur      = rem_reg[k-1];
                root_cur     = root_reg[k-1];
                rad_cur      = rad_reg[k-1];
                side_next[k] = side_reg[k-1];
                vld_next[k]  = vld_reg[k-1];
            end
            t            = {rem_cur, rad_cur[RAD_W-1:RAD_W-2]};
            trial        = {1'b0, root_cur, 2'b01};
            diff         = t - trial;
            take         = (t >= trial);
            rem_next[k]  = take ? diff[ROOT_W:0] : t[ROOT_W:0];
            root_next[k] = {root_cur[ROOT_W-2:0], take};
            rad_next[k]  = {rad_cur[RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

/* design/gpde_rotate.sv */
// ----------------------------------------------------------------------------
// gpde_rotate
// Two-stage 3x3 rotation in Q2.19: products, then row sums with floor shift
// and saturation. With rotation off the point passes through unchanged.
// ----------------------------------------------------------------------------
module gpde_rotate #(
    parameter int CW     = 32,
    parameter int SIDE_W = 63
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  gpde_pkg::mode_t                   mode,
    input  logic [gpde_pkg::CFG_DATA_W-1:0]   row_x,
    input  logic [gpde_pkg::CFG_DATA_W-1:0]   row_y,
    input  logic [gpde_pkg::CFG_DATA_W-1:0]   row_z,
    input  logic signed [CW-1:0]              x,
    input  logic signed [CW-1:0]              y,
    input  logic signed [CW-1:0]              z,
    input  logic [SIDE_W-1:0]                 side_in,
    output logic                              out_valid,
    output logic signed [CW-1:0]              x_out,
    output logic signed [CW-1:0]              y_out,
    output logic signed [CW-1:0]              z_out,
    output logic [SIDE_W-1:0]                 side_out
);

    localparam int CF_W   = gpde_pkg::COEF_W;
    localparam int PROD_W = CW + CF_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SH_W   = SUM_W - gpde_pkg::COEF_FRAC;

    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [PROD_W-1:0] prod_reg  [3][3];
    logic signed [CW-1:0]     pt_reg    [3];
    logic [SIDE_W-1:0]        a_side_reg;
    logic                     a_vld_reg;

    logic signed [CW-1:0]     res_next  [3];
    logic signed [CW-1:0]     res_reg   [3];
    logic [SIDE_W-1:0]        b_side_reg;
    logic                     b_vld_reg;

    logic [gpde_pkg::CFG_DATA_W-1:0] rows [3];
    logic signed [CW-1:0]            pt   [3];

    function automatic logic [CW-1:0] sat_cw(input logic [SH_W-1:0] v);
        logic ovf;
        ovf = (v[SH_W-1:CW-1] != {(SH_W-CW+1){v[SH_W-1]}});
        if (!ovf)
        begin
            return v[CW-1:0];
        end
        else if (v[SH_W-1])
        begin
            return {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    assign rows[0] = row_x;
    assign rows[1] = row_y;
    assign rows[2] = row_z;
    assign pt[0]   = x;
    assign pt[1]   = y;
    assign pt[2]   = z;

    always_comb
    begin
        logic signed [CF_W-1:0] coef;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                coef           = $signed(rows[r][CF_W*c +: CF_W]);
                prod_next[r][c] = coef * pt[c];
            end
        end
    end

    // The floor shift of the exact sum matches rounding toward minus infinity.
    always_comb
    begin
        logic signed [SUM_W-1:0] acc;
        for (int r = 0; r < 3; r++)
        begin
            acc = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                + SUM_W'(prod_reg[r][2]);
            res_next[r] = mode.rot_en ? sat_cw(acc[SUM_W-1:gpde_pkg::COEF_FRAC])
                                      : pt_reg[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            pt_reg     <= pt;
            a_side_reg <= side_in;
            res_reg    <= res_next;
            b_side_reg <= a_side_reg;
        end
    end

    assign out_valid = b_vld_reg;
    assign x_out     = res_reg[0];
    assign y_out     = res_reg[1];
    assign z_out     = res_reg[2];
    assign side_out  = b_side_reg;

endmodule

/* design/grid_plane_distance_estimate_unit.sv */
// ----------------------------------------------------------------------------
// grid_plane_distance_estimate_unit
// Latency is set by the bit-per-stage z divider, fold divider, square root and
// final divider.
// Throughput: one beat per cycle; the whole pipeline holds while a result waits.
// Reset clears all valid bits and loads the register defaults (identity matrix).
// ----------------------------------------------------------------------------
module grid_plane_distance_estimate_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [gpde_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [gpde_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [31:0]                pos_x,
    input  logic signed [31:0]                pos_y,
    input  logic signed [31:0]                pos_z,
    input  logic signed [31:0]                dist_in,
    input  logic [30:0]                       deriv_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [31:0]                dist_out
);

    localparam int CW     = COORD_WIDTH;
    localparam int PW     = gpde_pkg::POS_W;
    localparam int DW     = gpde_pkg::DERIV_W;
    localparam int SZW    = gpde_pkg::SIZE_W;
    localparam int FW     = gpde_pkg::FRAC_W;
    localparam int ZNW    = PW + FW;
    localparam int ZSW    = 1 + 3 * PW + DW;
    localparam int DDW    = PW + DW;
    localparam int FXSW   = 1 + CW + DDW;
    localparam int MAGW   = (CW > SZW) ? CW : SZW;
    localparam int RW     = MAGW + 1;
    localparam int SQW    = 2 * RW;
    localparam int AL     = CW / 2;
    localparam int AH     = CW - AL;
    localparam int NUMW   = RW + 2;
    localparam int NMAG   = NUMW - 1;
    localparam int NQW    = NMAG + FW;
    localparam int FDW    = PW;
    localparam int SQSW   = MAGW + DDW;

    // Configuration registers.
    logic [SZW-1:0]                   cell_size_reg;
    logic [SZW-1:0]                   z_scale_reg;
    logic signed [PW-1:0]             line_offset_reg;
    gpde_pkg::mode_t                  mode_reg;
    logic [gpde_pkg::CFG_DATA_W-1:0]  rot_row_x_reg;
    logic [gpde_pkg::CFG_DATA_W-1:0]  rot_row_y_reg;
    logic [gpde_pkg::CFG_DATA_W-1:0]  rot_row_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg   <= gpde_pkg::CELL_SIZE_RST;
            z_scale_reg     <= gpde_pkg::Z_SCALE_RST;
            line_offset_reg <= gpde_pkg::LINE_OFFSET_RST;
            mode_reg        <= '0;
            rot_row_x_reg   <= gpde_pkg::ROT_ROW_X_RST;
            rot_row_y_reg   <= gpde_pkg::ROT_ROW_Y_RST;
            rot_row_z_reg   <= gpde_pkg::ROT_ROW_Z_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (gpde_pkg::cfg_reg_t'(cfg_addr))
                gpde_pkg::REG_CELL_SIZE:   cell_size_reg   <= cfg_wdata[SZW-1:0];
                gpde_pkg::REG_Z_SCALE:     z_scale_reg     <= cfg_wdata[SZW-1:0];
                gpde_pkg::REG_LINE_OFFSET: line_offset_reg <= cfg_wdata[PW-1:0];
                gpde_pkg::REG_MODE_FLAGS:  mode_reg        <= cfg_wdata[1:0];
                gpde_pkg::REG_ROT_ROW_X:   rot_row_x_reg   <= cfg_wdata;
                gpde_pkg::REG_ROT_ROW_Y:   rot_row_y_reg   <= cfg_wdata;
                gpde_pkg::REG_ROT_ROW_Z:   rot_row_z_reg   <= cfg_wdata;
                default:                   ;
            endcase
        end
    end

    // A zero size or scale behaves as one.
    logic [SZW-1:0] size_eff;
    logic [SZW-1:0] zs_eff;
    assign size_eff = (cell_size_reg == '0) ? SZW'(1) : cell_size_reg;
    assign zs_eff   = (z_scale_reg == '0) ? SZW'(1) : z_scale_reg;

    logic en;
    logic out_valid_reg;
    logic signed [31:0] dist_out_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- z scaling divider ----------------
    logic [PW-1:0]  z_mag;
    logic [ZNW-1:0] zd_num;
    logic           zd_vld;
    logic [ZNW-1:0] zd_quo;
    logic [ZSW-1:0] zd_side;

    assign z_mag  = pos_z[PW-1] ? PW'(-pos_z) : PW'(pos_z);
    assign zd_num = {z_mag, {FW{1'b0}}};

    gpde_udiv #(.NUM_W(ZNW), .DEN_W(SZW), .SIDE_W(ZSW)) u_zdiv (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .num(zd_num), .den(zs_eff),
        .side_in({pos_z[PW-1], pos_x, pos_y, dist_in, deriv_in}),
        .out_valid(zd_vld), .quo(zd_quo), .rem(), .side_out(zd_side)
    );

    // ---------------- coordinate saturation ----------------
    function automatic logic [CW-1:0] sat_coord(input logic [ZNW:0] v);
        logic ovf;
        ovf = (v[ZNW:CW-1] != {(ZNW-CW+2){v[ZNW]}});
        if (!ovf)
        begin
            return v[CW-1:0];
        end
        else if (v[ZNW])
        begin
            return {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    logic [ZNW:0]         z_wide;
    logic [ZNW:0]         x_wide;
    logic [ZNW:0]         y_wide;
    logic signed [CW-1:0] s_x_reg, s_y_reg, s_z_reg;
    logic [DDW-1:0]       s_dd_reg;
    logic                 s_vld_reg;

    assign z_wide = zd_side[ZSW-1] ? (ZNW+1)'(-{1'b0, zd_quo}) : {1'b0, zd_quo};
    assign x_wide = (ZNW+1)'($signed(zd_side[ZSW-2 -: PW]));
    assign y_wide = (ZNW+1)'($signed(zd_side[ZSW-2-PW -: PW]));

    // ---------------- rotation ----------------
    logic                 r_vld;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic [DDW-1:0]       r_dd;

    gpde_rotate #(.CW(CW), .SIDE_W(DDW)) u_rotate (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_vld_reg), .mode(mode_reg),
        .row_x(rot_row_x_reg), .row_y(rot_row_y_reg), .row_z(rot_row_z_reg),
        .x(s_x_reg), .y(s_y_reg), .z(s_z_reg), .side_in(s_dd_reg),
        .out_valid(r_vld), .x_out(r_x), .y_out(r_y), .z_out(r_z), .side_out(r_dd)
    );

    // ---------------- fold dividers ----------------
    logic [CW-1:0]   x_mag, y_mag;
    logic            fx_vld, fy_vld;
    logic [SZW-1:0]  fx_rem, fy_rem;
    logic [FXSW-1:0] fx_side;
    logic            fy_neg;

    assign x_mag = r_x[CW-1] ? CW'(-r_x) : CW'(r_x);
    assign y_mag = r_y[CW-1] ? CW'(-r_y) : CW'(r_y);

    gpde_udiv #(.NUM_W(CW), .DEN_W(SZW), .SIDE_W(FXSW)) u_fold_x (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(r_vld),
        .num(x_mag), .den(size_eff), .side_in({r_x[CW-1], r_z, r_dd}),
        .out_valid(fx_vld), .quo(), .rem(fx_rem), .side_out(fx_side)
    );

    gpde_udiv #(.NUM_W(CW), .DEN_W(SZW), .SIDE_W(1)) u_fold_y (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(r_vld),
        .num(y_mag), .den(size_eff), .side_in(r_y[CW-1]),
        .out_valid(fy_vld), .quo(), .rem(fy_rem), .side_out(fy_neg)
    );

    // Floor modulo: a negative coordinate with a non-zero remainder wraps.
    logic [SZW-1:0]       f1_rx_reg, f1_ry_reg;
    logic signed [CW-1:0] f1_z_reg;
    logic [DDW-1:0]       f1_dd_reg;
    logic                 f1_vld_reg;

    logic [SZW-1:0] dx, dy;
    logic [SZW-1:0] f2_g_reg;
    logic [CW-1:0]  f2_az_reg;
    logic [DDW-1:0] f2_dd_reg;
    logic           f2_vld_reg;

    assign dx = ({f1_rx_reg, 1'b0} < {1'b0, size_eff}) ? f1_rx_reg : size_eff - f1_rx_reg;
    assign dy = ({f1_ry_reg, 1'b0} < {1'b0, size_eff}) ? f1_ry_reg : size_eff - f1_ry_reg;

    // ---------------- squares ----------------
    logic [2*SZW-1:0] q1_gsq_reg;
    logic [2*AH-1:0]  q1_hh_reg;
    logic [AH+AL-1:0] q1_hl_reg;
    logic [2*AL-1:0]  q1_ll_reg;
    logic [MAGW-1:0]  q1_cheb_reg;
    logic [DDW-1:0]   q1_dd_reg;
    logic             q1_vld_reg;

    logic [SQW-1:0]   q2_rad_reg;
    logic [MAGW-1:0]  q2_cheb_reg;
    logic [DDW-1:0]   q2_dd_reg;
    logic             q2_vld_reg;

    // ---------------- square root ----------------
    logic            sq_vld;
    logic [RW-1:0]   sq_root;
    logic [SQSW-1:0] sq_side;

    gpde_isqrt #(.ROOT_W(RW), .SIDE_W(SQSW)) u_isqrt (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(q2_vld_reg),
        .rad(q2_rad_reg), .side_in({q2_cheb_reg, q2_dd_reg}),
        .out_valid(sq_vld), .root(sq_root), .side_out(sq_side)
    );

    // ---------------- offset and divisor ----------------
    logic [RW-1:0]          grid;
    logic signed [NUMW-1:0] n1_num_reg;
    logic [DDW-1:0]         n1_dd_reg;
    logic                   n1_vld_reg;

    logic [NMAG-1:0]        n2_mag_reg;
    logic                   n2_neg_reg;
    logic [FDW-1:0]         n2_den_reg;
    logic signed [PW-1:0]   n2_dist_reg;
    logic                   n2_vld_reg;
    logic [NUMW-1:0]        num_abs;

    assign grid    = mode_reg.cheb ? RW'(sq_side[SQSW-1 -: MAGW]) : sq_root;
    assign num_abs = n1_num_reg[NUMW-1] ? NUMW'(-n1_num_reg) : NUMW'(n1_num_reg);

    // ---------------- final divider ----------------
    logic           fd_vld;
    logic [NQW-1:0] fd_quo;
    logic [PW:0]    fd_side;

    gpde_udiv #(.NUM_W(NQW), .DEN_W(FDW), .SIDE_W(PW + 1)) u_fdiv (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(n2_vld_reg),
        .num({n2_mag_reg, {FW{1'b0}}}), .den(n2_den_reg),
        .side_in({n2_neg_reg, n2_dist_reg}),
        .out_valid(fd_vld), .quo(fd_quo), .rem(), .side_out(fd_side)
    );

    // Saturate the signed quotient, then take the minimum with the incoming distance.
    logic                 q_big;
    logic                 fd_neg;
    logic signed [PW-1:0] fd_dist;
    logic signed [PW-1:0] res_sat;
    logic signed [PW-1:0] res_min;

    assign fd_neg  = fd_side[PW];
    assign fd_dist = fd_side[PW-1:0];
    assign q_big   = |fd_quo[NQW-1:PW];

    always_comb
    begin
        if (!fd_neg)
        begin
            res_sat = (q_big || fd_quo[PW-1]) ? {1'b0, {(PW-1){1'b1}}} : fd_quo[PW-1:0];
        end
        else if (q_big || (fd_quo[PW-1] && (|fd_quo[PW-2:0])))
        begin
            res_sat = {1'b1, {(PW-1){1'b0}}};
        end
        else
        begin
            res_sat = PW'(-fd_quo[PW-1:0]);
        end
        res_min = (fd_dist < res_sat) ? fd_dist : res_sat;
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg     <= 1'b0;
            f1_vld_reg    <= 1'b0;
            f2_vld_reg    <= 1'b0;
            q1_vld_reg    <= 1'b0;
            q2_vld_reg    <= 1'b0;
            n1_vld_reg    <= 1'b0;
            n2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s_vld_reg     <= zd_vld;
            f1_vld_reg    <= fx_vld && fy_vld;
            f2_vld_reg    <= f1_vld_reg;
            q1_vld_reg    <= f2_vld_reg;
            q2_vld_reg    <= q1_vld_reg;
            n1_vld_reg    <= sq_vld;
            n2_vld_reg    <= n1_vld_reg;
            out_valid_reg <= fd_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_x_reg  <= sat_coord(x_wide);
            s_y_reg  <= sat_coord(y_wide);
            s_z_reg  <= sat_coord(z_wide);
            s_dd_reg <= zd_side[DDW-1:0];

            f1_rx_reg <= (fx_side[FXSW-1] && (fx_rem != '0)) ? size_eff - fx_rem : fx_rem;
            f1_ry_reg <= (fy_neg && (fy_rem != '0)) ? size_eff - fy_rem : fy_rem;
            f1_z_reg  <= fx_side[FXSW-2 -: CW];
            f1_dd_reg <= fx_side[DDW-1:0];

            f2_g_reg  <= (dx < dy) ? dx : dy;
            f2_az_reg <= f1_z_reg[CW-1] ? CW'(-f1_z_reg) : CW'(f1_z_reg);
            f2_dd_reg <= f1_dd_reg;

            q1_gsq_reg  <= f2_g_reg * f2_g_reg;
            q1_hh_reg   <= f2_az_reg[CW-1:AL] * f2_az_reg[CW-1:AL];
            q1_hl_reg   <= f2_az_reg[CW-1:AL] * f2_az_reg[AL-1:0];
            q1_ll_reg   <= f2_az_reg[AL-1:0] * f2_az_reg[AL-1:0];
            q1_cheb_reg <= (MAGW'(f2_g_reg) > MAGW'(f2_az_reg)) ? MAGW'(f2_g_reg)
                                                                  : MAGW'(f2_az_reg);
            q1_dd_reg   <= f2_dd_reg;

            q2_rad_reg  <= SQW'(q1_gsq_reg) + (SQW'(q1_hh_reg) << (2 * AL))
                         + (SQW'(q1_hl_reg) << (AL + 1)) + SQW'(q1_ll_reg);
            q2_cheb_reg <= q1_cheb_reg;
            q2_dd_reg   <= q1_dd_reg;

            n1_num_reg <= NUMW'(grid) - NUMW'(line_offset_reg);
            n1_dd_reg  <= sq_side[DDW-1:0];

            n2_neg_reg  <= n1_num_reg[NUMW-1];
            n2_mag_reg  <= num_abs[NMAG-1:0];
            n2_den_reg  <= FDW'(n1_dd_reg[DW-1:0]) + FDW'(1 << FW);
            n2_dist_reg <= n1_dd_reg[DDW-1:DW];

            dist_out_reg <= res_min;
        end
    end

    assign out_valid = out_valid_reg;
    assign dist_out  = dist_out_reg;

endmodule

/* design/gpde_checker.sv */
// ----------------------------------------------------------------------------
// gpde_checker
// Port-level checks of the grid-plane distance unit, bound to the top level.
// ----------------------------------------------------------------------------
module gpde_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] dist_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dist_out))
        else $error("result beat changed while stalled");

    // A held result freezes the pipe, so no new beat may enter.
    a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while the output was stalled");

    a_free_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with the output register empty");

    // The asynchronous reset clears the output flag, so it stays low while reset is held.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown during reset");

endmodule

bind grid_plane_distance_estimate_unit gpde_checker u_gpde_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .dist_out(dist_out)
);
